>>> hw/rtl/abba_pkg.sv
// shared types and constants for the alpha bounding box autocrop core
package abba_pkg;

  localparam int CFG_W      = 13;
  localparam int CFG_IDX_W  = 1;
  localparam int COORD_W    = 12;
  localparam int ALPHA_W    = 8;
  localparam int CFG_MAX    = (2 ** CFG_W) - 1;
  localparam int DIM_RESET  = 4096;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

  typedef struct packed {
    logic               found;
    logic [COORD_W-1:0] min_x;
    logic [COORD_W-1:0] min_y;
    logic [COORD_W-1:0] max_x;
    logic [COORD_W-1:0] max_y;
  } box_t;

endpackage

>>> hw/rtl/abba_cfg.sv
// frame size registers with write-time saturation
module abba_cfg #(
  parameter int DIM_MAX = 4096,
  parameter int DIM_W   = 13
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [abba_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [abba_pkg::CFG_W-1:0]      cfg_data,
  output logic [DIM_W-1:0]                frame_width,
  output logic [DIM_W-1:0]                frame_height
);

  localparam int DIM_RST = (abba_pkg::DIM_RESET > DIM_MAX) ? DIM_MAX : abba_pkg::DIM_RESET;

  logic [DIM_W-1:0] width_r;
  logic [DIM_W-1:0] width_nxt;
  logic [DIM_W-1:0] height_r;
  logic [DIM_W-1:0] height_nxt;
  logic [DIM_W-1:0] clamped;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [abba_pkg::CFG_W-1:0] v);
    logic [31:0] v_ext;
    logic [DIM_W-1:0] res;
    v_ext = 32'(v);
    if (v_ext == 32'd0) begin
      res = DIM_W'(1);
    end else if (v_ext > 32'(DIM_MAX)) begin
      res = DIM_W'(DIM_MAX);
    end else begin
      res = DIM_W'(v);
    end
    return res;
  endfunction

  assign clamped = clamp_dim(cfg_data);

  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    if (cfg_we) begin
      unique case (cfg_index)
        abba_pkg::REG_FRAME_WIDTH:  width_nxt  = clamped;
        abba_pkg::REG_FRAME_HEIGHT: height_nxt = clamped;
        default:                    width_nxt  = width_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= DIM_W'(DIM_RST);
      height_r <= DIM_W'(DIM_RST);
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
    end
  end

  assign frame_width  = width_r;
  assign frame_height = height_r;

endmodule

>>> hw/rtl/abba_track.sv
// raster position counters and opaque pixel bounds
module abba_track #(
  parameter int DIM_W   = 13,
  parameter int CNT_W   = 12,
  parameter int DIM_RST = 4096
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          pix_valid,
  input  logic [abba_pkg::ALPHA_W-1:0]  pix_alpha,
  input  logic [DIM_W-1:0]              frame_width,
  input  logic [DIM_W-1:0]              frame_height,
  output logic                          frame_end,
  output abba_pkg::box_t                box
);

  localparam int EXT_W = abba_pkg::COORD_W + CNT_W;

  logic [CNT_W-1:0] col_r, col_nxt;
  logic [CNT_W-1:0] row_r, row_nxt;
  logic [DIM_W-1:0] lc_r, lc_nxt, lc_upd;
  logic [DIM_W-1:0] lr_r, lr_nxt, lr_upd;
  logic [CNT_W-1:0] gc_r, gc_nxt, gc_upd;
  logic [CNT_W-1:0] gr_r, gr_nxt, gr_upd;
  logic             opaque;
  logic             row_end;
  logic             found;
  logic [EXT_W-1:0] lc_ext, lr_ext, gc_ext, gr_ext;

  assign opaque = (pix_alpha != '0);

  assign lc_upd = (opaque && (DIM_W'(col_r) < lc_r)) ? DIM_W'(col_r) : lc_r;
  assign lr_upd = (opaque && (DIM_W'(row_r) < lr_r)) ? DIM_W'(row_r) : lr_r;
  assign gc_upd = (opaque && (col_r > gc_r)) ? col_r : gc_r;
  assign gr_upd = (opaque && (row_r > gr_r)) ? row_r : gr_r;

  assign row_end   = (DIM_W'(col_r) + DIM_W'(1)) >= frame_width;
  assign frame_end = row_end && ((DIM_W'(row_r) + DIM_W'(1)) >= frame_height);

  assign found = (lc_upd < DIM_W'(gc_upd)) && (lr_upd < DIM_W'(gr_upd));

  // bounds are below the frame size when found, so the counter width holds them
  assign lc_ext = {{abba_pkg::COORD_W{1'b0}}, CNT_W'(lc_upd)};
  assign lr_ext = {{abba_pkg::COORD_W{1'b0}}, CNT_W'(lr_upd)};
  assign gc_ext = {{abba_pkg::COORD_W{1'b0}}, gc_upd};
  assign gr_ext = {{abba_pkg::COORD_W{1'b0}}, gr_upd};

  always_comb begin
    box.found = found;
    box.min_x = found ? lc_ext[abba_pkg::COORD_W-1:0] : '0;
    box.min_y = found ? lr_ext[abba_pkg::COORD_W-1:0] : '0;
    box.max_x = found ? gc_ext[abba_pkg::COORD_W-1:0] : '0;
    box.max_y = found ? gr_ext[abba_pkg::COORD_W-1:0] : '0;
  end

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    lc_nxt  = lc_r;
    lr_nxt  = lr_r;
    gc_nxt  = gc_r;
    gr_nxt  = gr_r;
    if (pix_valid) begin
      priority if (frame_end) begin
        col_nxt = '0;
        row_nxt = '0;
        lc_nxt  = frame_width;
        lr_nxt  = frame_height;
        gc_nxt  = '0;
        gr_nxt  = '0;
      end else if (row_end) begin
        col_nxt = '0;
        row_nxt = row_r + CNT_W'(1);
        lc_nxt  = lc_upd;
        lr_nxt  = lr_upd;
        gc_nxt  = gc_upd;
        gr_nxt  = gr_upd;
      end else begin
        col_nxt = col_r + CNT_W'(1);
        lc_nxt  = lc_upd;
        lr_nxt  = lr_upd;
        gc_nxt  = gc_upd;
        gr_nxt  = gr_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      lc_r  <= DIM_W'(DIM_RST);
      lr_r  <= DIM_W'(DIM_RST);
      gc_r  <= '0;
      gr_r  <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      lc_r  <= lc_nxt;
      lr_r  <= lr_nxt;
      gc_r  <= gc_nxt;
      gr_r  <= gr_nxt;
    end
  end

  a_col_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    pix_valid && frame_end |=> (col_r == '0) && (row_r == '0) && (gc_r == '0))
    else $error("position not restarted after frame end");

endmodule

>>> hw/rtl/alpha_bounding_box_autocrop_core.sv
// Alpha bounding box autocrop core: takes one alpha beat per clock in raster order
// while in_stall is low and gives one result beat after the last pixel of each
// frame, holding the least and greatest opaque column and row when the box has
// positive extent in both directions (coordinates zero otherwise). Throughput is
// one pixel per cycle unless stalled; a pixel goes through an input register and
// the bounds compare-update stage, whose result is captured in the result register.
// The single result register applies backpressure only while it holds an
// untaken result. Frame size writes saturate to 1..MAX_DIM.
module alpha_bounding_box_autocrop_core #(
  parameter int MAX_DIM = 4096
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [abba_pkg::ALPHA_W-1:0]      in_pixel_alpha,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_box_found,
  output logic [abba_pkg::COORD_W-1:0]      out_box_min_x,
  output logic [abba_pkg::COORD_W-1:0]      out_box_min_y,
  output logic [abba_pkg::COORD_W-1:0]      out_box_max_x,
  output logic [abba_pkg::COORD_W-1:0]      out_box_max_y,
  input  logic                              cfg_we,
  input  logic [abba_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [abba_pkg::CFG_W-1:0]        cfg_data
);

  localparam int DIM_MAX = (MAX_DIM < abba_pkg::CFG_MAX) ? MAX_DIM : abba_pkg::CFG_MAX;
  localparam int DIM_W   = $clog2(DIM_MAX + 1);
  localparam int CNT_W   = $clog2(DIM_MAX);
  localparam int DIM_RST = (abba_pkg::DIM_RESET > DIM_MAX) ? DIM_MAX : abba_pkg::DIM_RESET;

  logic [DIM_W-1:0]               frame_width;
  logic [DIM_W-1:0]               frame_height;
  logic                           pix_valid_r, pix_valid_nxt;
  logic [abba_pkg::ALPHA_W-1:0]   pix_alpha_r, pix_alpha_nxt;
  logic                           out_valid_r, out_valid_nxt;
  abba_pkg::box_t                 box_r, box_nxt;
  abba_pkg::box_t                 trk_box;
  logic                           trk_end;
  logic                           advance;
  logic                           in_take;

  abba_cfg #(
    .DIM_MAX (DIM_MAX),
    .DIM_W   (DIM_W)
  ) u_cfg (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .frame_width  (frame_width),
    .frame_height (frame_height)
  );

  // stage advances unless a finished result is still waiting
  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = pix_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  abba_track #(
    .DIM_W   (DIM_W),
    .CNT_W   (CNT_W),
    .DIM_RST (DIM_RST)
  ) u_track (
    .clk          (clk),
    .rst_n        (rst_n),
    .pix_valid    (pix_valid_r && advance),
    .pix_alpha    (pix_alpha_r),
    .frame_width  (frame_width),
    .frame_height (frame_height),
    .frame_end    (trk_end),
    .box          (trk_box)
  );

  always_comb begin
    pix_valid_nxt = pix_valid_r;
    pix_alpha_nxt = pix_alpha_r;
    if (advance || !pix_valid_r) begin
      pix_valid_nxt = in_take;
      pix_alpha_nxt = in_pixel_alpha;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    box_nxt       = box_r;
    if (advance) begin
      out_valid_nxt = pix_valid_r && trk_end;
      box_nxt       = trk_box;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pix_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pix_valid_r <= pix_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pix_alpha_r <= pix_alpha_nxt;
    box_r       <= box_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_box_found = box_r.found;
  assign out_box_min_x = box_r.min_x;
  assign out_box_min_y = box_r.min_y;
  assign out_box_max_x = box_r.max_x;
  assign out_box_max_y = box_r.max_y;

  a_found_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && box_r.found |-> (box_r.min_x < box_r.max_x) && (box_r.min_y < box_r.max_y))
    else $error("found box without positive extent");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !box_r.found |->
      (box_r.min_x == '0) && (box_r.min_y == '0) && (box_r.max_x == '0) && (box_r.max_y == '0))
    else $error("empty box with nonzero coordinates");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> pix_valid_r && out_valid_r && out_stall)
    else $error("input stalled without a waiting result");

  a_held_pixel: assert property (@(posedge clk) disable iff (!rst_n)
    pix_valid_r && !advance |=> pix_valid_r && $stable(pix_alpha_r))
    else $error("pending pixel lost while result waits");

endmodule

>>> tb/alpha_bounding_box_autocrop_core_tb.sv
// testbench for the alpha bounding box autocrop core: frame streams checked against a box predictor
module alpha_bounding_box_autocrop_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_DIM       = 4096;
  localparam int HOLD_CYCLES   = 300;
  localparam int RANDOM_PIXELS = 1280;
  localparam int DRAIN_CYCLES  = 6;
  localparam int IDLE_PCT      = 21;

  class box_book;
    logic [abba_pkg::CFG_W-1:0]   width;
    logic [abba_pkg::CFG_W-1:0]   height;
    logic [abba_pkg::COORD_W-1:0] col;
    logic [abba_pkg::COORD_W-1:0] row;
    logic [abba_pkg::CFG_W-1:0]   least_col;
    logic [abba_pkg::CFG_W-1:0]   least_row;
    logic [abba_pkg::COORD_W-1:0] great_col;
    logic [abba_pkg::COORD_W-1:0] great_row;
    abba_pkg::box_t               pending[$];
    int                           errors = 0;

    function void restart();
      col       = '0;
      row       = '0;
      least_col = width;
      least_row = height;
      great_col = '0;
      great_row = '0;
    endfunction

    function void reset_all();
      width  = abba_pkg::CFG_W'(MAX_DIM);
      height = abba_pkg::CFG_W'(MAX_DIM);
      restart();
    endfunction

    function void write_reg(logic [abba_pkg::CFG_IDX_W-1:0] idx,
                            logic [abba_pkg::CFG_W-1:0] data);
      logic [abba_pkg::CFG_W-1:0] dim;
      dim = data;
      if (dim == '0) begin
        dim = abba_pkg::CFG_W'(1);
      end else if (dim > abba_pkg::CFG_W'(MAX_DIM)) begin
        dim = abba_pkg::CFG_W'(MAX_DIM);
      end
      if (idx == abba_pkg::REG_FRAME_WIDTH) begin
        width = dim;
      end else begin
        height = dim;
      end
    endfunction

    function void note_pixel(logic [abba_pkg::ALPHA_W-1:0] alpha);
      abba_pkg::box_t res;
      if (alpha != '0) begin
        if ({1'b0, col} < least_col) least_col = {1'b0, col};
        if ({1'b0, row} < least_row) least_row = {1'b0, row};
        if (col > great_col) great_col = col;
        if (row > great_row) great_row = row;
      end
      if ({1'b0, col} + abba_pkg::CFG_W'(1) < width) begin
        col++;
        return;
      end
      col = '0;
      if ({1'b0, row} + abba_pkg::CFG_W'(1) < height) begin
        row++;
        return;
      end
      res = '0;
      if (least_col < {1'b0, great_col} && least_row < {1'b0, great_row}) begin
        res.found = 1'b1;
        res.min_x = least_col[abba_pkg::COORD_W-1:0];
        res.min_y = least_row[abba_pkg::COORD_W-1:0];
        res.max_x = great_col;
        res.max_y = great_row;
      end
      pending.push_back(res);
      restart();
    endfunction

    function void check_box(abba_pkg::box_t got);
      abba_pkg::box_t want;
      if (pending.size() == 0) begin
        $error("box beat with none expected");
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.found !== want.found) begin
        $error("box_found expected %0d got %0d", want.found, got.found);
        errors++;
      end
      if (got.min_x !== want.min_x) begin
        $error("box_min_x expected %0d got %0d", want.min_x, got.min_x);
        errors++;
      end
      if (got.min_y !== want.min_y) begin
        $error("box_min_y expected %0d got %0d", want.min_y, got.min_y);
        errors++;
      end
      if (got.max_x !== want.max_x) begin
        $error("box_max_x expected %0d got %0d", want.max_x, got.max_x);
        errors++;
      end
      if (got.max_y !== want.max_y) begin
        $error("box_max_y expected %0d got %0d", want.max_y, got.max_y);
        errors++;
      end
    endfunction
  endclass

  logic                           clk;
  logic                           rst_n;
  logic                           in_valid;
  logic                           in_stall;
  logic [abba_pkg::ALPHA_W-1:0]   in_pixel_alpha;
  logic                           out_valid;
  logic                           out_stall;
  logic                           out_box_found;
  logic [abba_pkg::COORD_W-1:0]   out_box_min_x;
  logic [abba_pkg::COORD_W-1:0]   out_box_min_y;
  logic [abba_pkg::COORD_W-1:0]   out_box_max_x;
  logic [abba_pkg::COORD_W-1:0]   out_box_max_y;
  logic                           cfg_we;
  logic [abba_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [abba_pkg::CFG_W-1:0]     cfg_data;

  box_book        book;
  abba_pkg::box_t seen_box;
  bit             idle_on;
  bit             hold_req;

  alpha_bounding_box_autocrop_core #(
    .MAX_DIM(MAX_DIM)
  ) u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_pixel_alpha(in_pixel_alpha),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_box_found (out_box_found),
    .out_box_min_x (out_box_min_x),
    .out_box_min_y (out_box_min_y),
    .out_box_max_x (out_box_max_x),
    .out_box_max_y (out_box_max_y),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  task automatic send_pixel(input logic [abba_pkg::ALPHA_W-1:0] alpha);
    while (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid       = 1'b0;
      in_pixel_alpha = abba_pkg::ALPHA_W'($urandom);
      @(negedge clk);
    end
    in_valid       = 1'b1;
    in_pixel_alpha = alpha;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    book.note_pixel(alpha);
    @(negedge clk);
  endtask

  task automatic write_dims(input bit do_w, input bit do_h,
                            input logic [abba_pkg::CFG_W-1:0] w,
                            input logic [abba_pkg::CFG_W-1:0] h);
    if (do_w) begin
      cfg_we    = 1'b1;
      cfg_index = abba_pkg::REG_FRAME_WIDTH;
      cfg_data  = w;
      @(negedge clk);
      book.write_reg(abba_pkg::REG_FRAME_WIDTH, w);
    end
    if (do_h) begin
      cfg_we    = 1'b1;
      cfg_index = abba_pkg::REG_FRAME_HEIGHT;
      cfg_data  = h;
      @(negedge clk);
      book.write_reg(abba_pkg::REG_FRAME_HEIGHT, h);
    end
    cfg_we = 1'b0;
  endtask

  task automatic settle();
    in_valid = 1'b0;
    while (book.pending.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic send_random_frame(input int pct);
    int total;
    total = int'(book.width) * int'(book.height);
    for (int i = 0; i < total; i++) begin
      send_pixel(($urandom_range(0, 99) < pct) ?
                 abba_pkg::ALPHA_W'($urandom_range(1, 255)) : '0);
    end
  endtask

  // opaque only at two given points
  task automatic send_corner_frame(input int x0, input int y0, input int x1, input int y1);
    int w;
    int h;
    w = int'(book.width);
    h = int'(book.height);
    for (int r = 0; r < h; r++) begin
      for (int c = 0; c < w; c++) begin
        send_pixel(((c == x0 && r == y0) || (c == x1 && r == y1)) ?
                   abba_pkg::ALPHA_W'($urandom_range(1, 255)) : '0);
      end
    end
  endtask

  function automatic logic [abba_pkg::CFG_W-1:0] pick_dim();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r == 1) return abba_pkg::CFG_W'(1);
    if (r < 16) return abba_pkg::CFG_W'($urandom_range(2, 6));
    return abba_pkg::CFG_W'($urandom_range(7, 16));
  endfunction

  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      out_stall = idle_on && ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      seen_box.found = out_box_found;
      seen_box.min_x = out_box_min_x;
      seen_box.min_y = out_box_min_y;
      seen_box.max_x = out_box_max_x;
      seen_box.max_y = out_box_max_y;
      book.check_box(seen_box);
    end
  end

  initial begin
    #5_000_000;
    $display("alpha_bounding_box_autocrop_core_tb NOT OK");
    $finish;
  end

  initial begin
    int rand_pixels;
    int frames;
    int pct;
    int sel;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_pixel_alpha = '0;
    cfg_we         = 1'b0;
    cfg_index      = abba_pkg::REG_FRAME_WIDTH;
    cfg_data       = '0;
    idle_on        = 1'b1;
    hold_req       = 1'b0;
    book = new();
    book.reset_all();
    repeat (4) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // zero writes saturate to a single-pixel frame
    write_dims(1'b1, 1'b1, '0, '0);
    send_pixel(8'hFF);
    send_pixel(8'h00);
    settle();

    write_dims(1'b1, 1'b1, abba_pkg::CFG_W'(3), abba_pkg::CFG_W'(3));
    for (int i = 0; i < 9; i++) send_pixel(i == 0 ? 8'h01 : (i == 8 ? 8'h80 : 8'h00));
    for (int i = 0; i < 9; i++) send_pixel(i == 4 ? 8'hFF : 8'h00);
    settle();

    // wide and tall frames with the box at the far edges
    idle_on = 1'b0;
    write_dims(1'b1, 1'b1, abba_pkg::CFG_W'(40), abba_pkg::CFG_W'(3));
    send_corner_frame(38, 0, 39, 2);
    settle();
    idle_on = 1'b1;

    write_dims(1'b1, 1'b1, abba_pkg::CFG_W'(3), abba_pkg::CFG_W'(40));
    send_corner_frame(0, 38, 2, 39);
    settle();

    // receiver holds off while small frames keep coming
    write_dims(1'b1, 1'b1, abba_pkg::CFG_W'(2), abba_pkg::CFG_W'(2));
    hold_req = 1'b1;
    repeat (30) send_random_frame(50);
    rand_pixels = 120;

    while (rand_pixels < RANDOM_PIXELS) begin
      settle();
      idle_on = !(rand_pixels >= 600 && rand_pixels < 900);
      sel = $urandom_range(0, 9);
      write_dims(sel != 8, sel != 7, pick_dim(), pick_dim());
      frames = $urandom_range(1, 4);
      repeat (frames) begin
        case ($urandom_range(0, 4))
          0: pct = 0;
          1: pct = 3;
          2: pct = 20;
          3: pct = 60;
          default: pct = 100;
        endcase
        send_random_frame(pct);
        rand_pixels += int'(book.width) * int'(book.height);
      end
    end
    settle();

    if (book.errors == 0) begin
      $display("alpha_bounding_box_autocrop_core_tb OK");
    end else begin
      $display("alpha_bounding_box_autocrop_core_tb NOT OK");
    end
    $finish;
  end

endmodule
